// ===== rtl/pccc_turbo_block_encoder_core_macros.svh =====
// Assertion macros shared by the turbo block encoder modules.
`ifndef PCCC_TURBO_BLOCK_ENCODER_CORE_MACROS_SVH
`define PCCC_TURBO_BLOCK_ENCODER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk and switched off during reset.
`define PCCC_TBE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and switched off during reset.
`define PCCC_TBE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
        else $error(msg);

`endif

// ===== rtl/pccc_tbe_pkg.sv =====
// Shared constants, codes and types of the turbo block encoder.
package pccc_tbe_pkg;

    // Default sizes of the stores.
    localparam int DEF_MAX_BLOCK   = 64;
    localparam int DEF_MAX_STATES  = 64;
    localparam int DEF_MAX_SYMBOLS = 16;

    // Field widths.
    localparam int CMD_W     = 2;
    localparam int INDEX_W   = 10;
    localparam int STATE_W   = 6;
    localparam int SYM_W     = 4;
    localparam int NI_W      = 5;
    localparam int BLEN_W    = 7;
    localparam int CODE_W    = 8;
    localparam int ENTRY_W   = STATE_W + SYM_W;
    // state * num_inputs + symbol stays below 2048.
    localparam int SUM_W     = STATE_W + NI_W;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 7;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_START_ONE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_TWO = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_IN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_OUT2  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LEN = 3'd4;

    // Item commands.
    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD_ONE  = 2'd0,
        CMD_LOAD_TWO  = 2'd1,
        CMD_LOAD_PERM = 2'd2,
        CMD_DATA      = 2'd3
    } cmd_t;

    // Step strobes from the sequencer to each trellis lane.
    typedef struct packed {
        logic load_addr;
        logic load_quot;
    } lane_ctl_t;

endpackage

// ===== rtl/pccc_tbe_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module pccc_tbe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ram_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= ram_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/pccc_tbe_lane.sv =====
// One trellis lane: transition table, address arithmetic and state feedback.
`include "pccc_turbo_block_encoder_core_macros.svh"

module pccc_tbe_lane #(
    parameter int DEPTH = pccc_tbe_pkg::DEF_MAX_STATES * pccc_tbe_pkg::DEF_MAX_SYMBOLS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             wr_en,
    input  logic [pccc_tbe_pkg::INDEX_W-1:0] wr_index,
    input  logic [pccc_tbe_pkg::STATE_W-1:0] wr_next_state,
    input  logic [pccc_tbe_pkg::SYM_W-1:0]   wr_out_symbol,
    input  pccc_tbe_pkg::lane_ctl_t          ctl,
    input  logic [pccc_tbe_pkg::STATE_W-1:0] start_state,
    input  logic                             use_start,
    input  logic [pccc_tbe_pkg::SYM_W-1:0]   symbol,
    input  logic [pccc_tbe_pkg::NI_W-1:0]    num_inputs,
    output logic [pccc_tbe_pkg::STATE_W-1:0] next_state,
    output logic [pccc_tbe_pkg::SYM_W-1:0]   out_symbol
);

    localparam int AW      = $clog2(DEPTH);
    localparam int XW      = pccc_tbe_pkg::SUM_W;
    localparam int Shift   = 20;
    localparam int Recip   = (1 << Shift) / DEPTH;
    localparam int RecipW  = $clog2(Recip + 1);
    localparam int MulW    = XW + RecipW;
    localparam int StateW  = pccc_tbe_pkg::STATE_W;
    localparam int EntryW  = pccc_tbe_pkg::ENTRY_W;

    logic [XW-1:0]     p_reg, p_next;
    logic [XW-1:0]     q_reg, q_next;
    logic [MulW-1:0]   mul;
    logic [XW-1:0]     part;
    logic [XW-1:0]     rem;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     wr_addr;
    logic              wr_ok;
    logic [EntryW-1:0] rd_data;
    logic [StateW-1:0] state;

    // The current state is the start state on the first position and the
    // table's next-state field afterwards.
    assign state  = use_start ? start_state : rd_data[EntryW-1 -: StateW];
    assign p_next = XW'(state) * XW'(num_inputs) + XW'(symbol);

    // Wrap to the table depth: the quotient estimate from the reciprocal is
    // at most one short, so one compare and subtract finishes it.
    assign mul    = MulW'(p_reg) * MulW'(Recip);
    assign q_next = XW'(mul >> Shift);
    assign part   = XW'(int'(q_reg) * DEPTH);
    assign rem    = p_reg - part;

    always_comb
    begin
        if (int'(rem) >= DEPTH)
        begin
            rd_addr = AW'(int'(rem) - DEPTH);
        end
        else
        begin
            rd_addr = AW'(rem);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_addr)
        begin
            p_reg <= p_next;
        end
        if (ctl.load_quot)
        begin
            q_reg <= q_next;
        end
    end

    assign wr_ok   = wr_en && (int'(wr_index) < DEPTH);
    assign wr_addr = AW'(wr_index);

    pccc_tbe_ram #(
        .WIDTH (EntryW),
        .DEPTH (DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_ok),
        .wr_addr (wr_addr),
        .wr_data ({wr_next_state, wr_out_symbol}),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign next_state = rd_data[EntryW-1 -: StateW];
    assign out_symbol = rd_data[pccc_tbe_pkg::SYM_W-1:0];

    `PCCC_TBE_ASSERT_NEXT(a_lane_addr_wrapped, ctl.load_addr, ##1 (int'(rd_addr) < DEPTH), "trellis address not wrapped into the table")

endmodule

// ===== rtl/pccc_turbo_block_encoder_core.sv =====
// Top level of the parallel concatenated trellis (turbo) block encoder.
//
// Items arrive on the in_* channel. Load commands write an entry of the first
// or second trellis table (next state and output symbol at
// state*num_inputs+symbol) or of the interleaver permutation; data commands
// append a symbol to the block buffer. Load items and data items that do not
// end a block leave the sequencer idle. The data symbol that fills the block
// (block_length symbols, 0 counting as 1 and anything above MAX_BLOCK as
// MAX_BLOCK) starts an encoding pass over the block, during which in_ready is
// low: F0 and F1 fetch the first symbol pair, T0, T1 and T2 step through each
// position, and FIN hands over the final result. The T0..T2 steps of each
// position are set by the state recurrence of each trellis: a multiply for
// state*num_inputs+symbol, a reciprocal multiply to wrap that sum into the table
// depth, and the registered read of the table that yields the next state. The
// buffer and permutation fetches for the following position overlap that loop.
// Results leave through an output register on the out_* channel, one transfer
// per position, with last set on the final one; a consumer that holds
// out_ready low stalls the pass without losing anything. Each result is
// o1*num_out2+o2 kept to 8 bits, where o1 comes from the first trellis on
// symbol i and o2 from the second on the symbol at the permuted position.
// bad_symbol flags a symbol at or above num_inputs (looked up as 0) or a
// permuted position outside the block. Configuration registers are written
// through cfg_wr_en, cfg_addr and cfg_wdata and must only change while the
// block is idle. Tables and buffers come out of reset unset and must be loaded
// before use; no clearing pass runs after reset.
`include "pccc_turbo_block_encoder_core_macros.svh"

module pccc_turbo_block_encoder_core #(
    parameter int MAX_BLOCK   = pccc_tbe_pkg::DEF_MAX_BLOCK,
    parameter int MAX_STATES  = pccc_tbe_pkg::DEF_MAX_STATES,
    parameter int MAX_SYMBOLS = pccc_tbe_pkg::DEF_MAX_SYMBOLS
) (
    input  logic                               clk,
    input  logic                               rst_n,

    // Configuration write port.
    input  logic                               cfg_wr_en,
    input  logic [pccc_tbe_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [pccc_tbe_pkg::CFG_DAT_W-1:0] cfg_wdata,

    // Input items.
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [pccc_tbe_pkg::CMD_W-1:0]     cmd,
    input  logic [pccc_tbe_pkg::INDEX_W-1:0]   table_index,
    input  logic [pccc_tbe_pkg::STATE_W-1:0]   next_state_value,
    input  logic [pccc_tbe_pkg::SYM_W-1:0]     out_symbol_value,
    input  logic [pccc_tbe_pkg::STATE_W-1:0]   perm_target,
    input  logic [pccc_tbe_pkg::SYM_W-1:0]     data_symbol,

    // Result items.
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [pccc_tbe_pkg::CODE_W-1:0]    code_symbol,
    output logic                               bad_symbol,
    output logic                               last
);

    localparam int TableDepth = MAX_STATES * MAX_SYMBOLS;
    localparam int BW         = $clog2(MAX_BLOCK);
    localparam int LW         = $clog2(MAX_BLOCK + 1);
    localparam int StateW     = pccc_tbe_pkg::STATE_W;
    localparam int SymW       = pccc_tbe_pkg::SYM_W;
    localparam int NiW        = pccc_tbe_pkg::NI_W;
    localparam int BlenW      = pccc_tbe_pkg::BLEN_W;
    localparam int CodeW      = pccc_tbe_pkg::CODE_W;
    localparam int MixW       = CodeW + 1;

    // Sequencer phases. F0/F1 fetch the first symbol pair; T0..T2 are the three
    // steps of one trellis position; FIN hands over the final result.
    typedef enum logic [6:0] {
        PH_IDLE = 7'b0000001,
        PH_F0   = 7'b0000010,
        PH_F1   = 7'b0000100,
        PH_T0   = 7'b0001000,
        PH_T1   = 7'b0010000,
        PH_T2   = 7'b0100000,
        PH_FIN  = 7'b1000000
    } phase_t;

    // Configuration registers.
    logic [StateW-1:0] start_one_reg, start_one_next;
    logic [StateW-1:0] start_two_reg, start_two_next;
    logic [NiW-1:0]    num_inputs_reg, num_inputs_next;
    logic [NiW-1:0]    num_out2_reg, num_out2_next;
    logic [BlenW-1:0]  block_length_reg, block_length_next;

    // Sequencer state.
    phase_t            phase_reg, phase_next;
    logic [BW-1:0]     fill_reg, fill_next;
    logic [LW-1:0]     len_reg, len_next;
    logic [BW-1:0]     pos_reg, pos_next;
    logic [BW-1:0]     fetch_pos_reg, fetch_pos_next;
    logic              out_valid_reg, out_valid_next;

    // Datapath registers.
    logic [SymW-1:0]   s1_reg;
    logic [StateW-1:0] k_reg;
    logic              bad_reg;
    logic [CodeW-1:0]  code_symbol_reg;
    logic              bad_symbol_reg;
    logic              last_reg;

    logic              in_accept;
    logic [LW-1:0]     eff_len;
    logic [LW-1:0]     fill_inc;
    logic              block_done;
    logic              out_free;
    logic              t0_go;
    logic              pos_last;
    logic              out_load;
    logic              out_is_last;
    logic              fetch_latch;

    logic [BW-1:0]     sbuf_rd_addr;
    logic [SymW-1:0]   sbuf_rd_data;
    logic              sbuf_wr_en;
    logic [StateW-1:0] perm_rd_data;
    logic              perm_wr_en;

    logic              k_in_block;
    logic              bad_one;
    logic              bad_two;
    logic [SymW-1:0]   sym_one;
    logic [SymW-1:0]   sym_two;
    logic              bad_now;

    pccc_tbe_pkg::lane_ctl_t lane_ctl;
    logic [StateW-1:0] lane_one_next;
    logic [StateW-1:0] lane_two_next;
    logic [SymW-1:0]   o1;
    logic [SymW-1:0]   o2;
    logic [MixW-1:0]   mix;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    always_comb
    begin
        start_one_next    = start_one_reg;
        start_two_next    = start_two_reg;
        num_inputs_next   = num_inputs_reg;
        num_out2_next     = num_out2_reg;
        block_length_next = block_length_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                pccc_tbe_pkg::CFG_START_ONE: start_one_next    = cfg_wdata[StateW-1:0];
                pccc_tbe_pkg::CFG_START_TWO: start_two_next    = cfg_wdata[StateW-1:0];
                pccc_tbe_pkg::CFG_NUM_IN:    num_inputs_next   = cfg_wdata[NiW-1:0];
                pccc_tbe_pkg::CFG_NUM_OUT2:  num_out2_next     = cfg_wdata[NiW-1:0];
                pccc_tbe_pkg::CFG_BLOCK_LEN: block_length_next = cfg_wdata[BlenW-1:0];
                default:
                begin
                    // Writes to unused indexes are dropped.
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Block fill bookkeeping
    // ------------------------------------------------------------------
    assign in_ready  = (phase_reg == PH_IDLE);
    assign in_accept = in_valid && in_ready;

    // Effective block length: zero acts as one, oversize acts as MAX_BLOCK.
    always_comb
    begin
        if (block_length_reg == '0)
        begin
            eff_len = LW'(1);
        end
        else if (int'(block_length_reg) > MAX_BLOCK)
        begin
            eff_len = LW'(MAX_BLOCK);
        end
        else
        begin
            eff_len = LW'(block_length_reg);
        end
    end

    // A shrunken block length closes the block on the next data symbol.
    assign fill_inc   = LW'(fill_reg) + LW'(1);
    assign block_done = (fill_inc >= eff_len);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    assign out_free = !out_valid_reg || out_ready;
    assign t0_go    = (pos_reg == '0) || out_free;
    assign pos_last = (LW'(pos_reg) + LW'(1)) == len_reg;

    always_comb
    begin
        phase_next     = phase_reg;
        fill_next      = fill_reg;
        len_next       = len_reg;
        pos_next       = pos_reg;
        fetch_pos_next = fetch_pos_reg;
        out_load       = 1'b0;
        out_is_last    = 1'b0;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (in_accept && (cmd == pccc_tbe_pkg::CMD_DATA))
                begin
                    if (block_done)
                    begin
                        phase_next     = PH_F0;
                        fill_next      = '0;
                        len_next       = fill_inc;
                        pos_next       = '0;
                        fetch_pos_next = '0;
                    end
                    else
                    begin
                        fill_next = BW'(fill_inc);
                    end
                end
            end
            PH_F0:
            begin
                phase_next = PH_F1;
            end
            PH_F1:
            begin
                phase_next = PH_T0;
            end
            PH_T0:
            begin
                // The previous position's result is ready in the tables' read
                // registers; it waits here until the output register frees.
                if (t0_go)
                begin
                    phase_next     = PH_T1;
                    fetch_pos_next = pos_reg + BW'(1);
                    out_load       = (pos_reg != '0);
                end
            end
            PH_T1:
            begin
                phase_next = PH_T2;
            end
            PH_T2:
            begin
                if (pos_last)
                begin
                    phase_next = PH_FIN;
                end
                else
                begin
                    phase_next = PH_T0;
                    pos_next   = pos_reg + BW'(1);
                end
            end
            PH_FIN:
            begin
                if (out_free)
                begin
                    phase_next  = PH_IDLE;
                    out_load    = 1'b1;
                    out_is_last = 1'b1;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_one_reg    <= '0;
            start_two_reg    <= '0;
            num_inputs_reg   <= NiW'(2);
            num_out2_reg     <= NiW'(2);
            block_length_reg <= BlenW'(64);
            phase_reg        <= PH_IDLE;
            fill_reg         <= '0;
            len_reg          <= '0;
            pos_reg          <= '0;
            fetch_pos_reg    <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            start_one_reg    <= start_one_next;
            start_two_reg    <= start_two_next;
            num_inputs_reg   <= num_inputs_next;
            num_out2_reg     <= num_out2_next;
            block_length_reg <= block_length_next;
            phase_reg        <= phase_next;
            fill_reg         <= fill_next;
            len_reg          <= len_next;
            pos_reg          <= pos_next;
            fetch_pos_reg    <= fetch_pos_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Symbol buffer and permutation memories
    // ------------------------------------------------------------------
    // The fetch of the next position's symbol pair runs alongside the trellis
    // steps: buffer and permutation are read at the position in F0/T1, the
    // buffer again at the permuted position in F1/T2, and that address is held
    // through T0 so a stall leaves the read data in place.
    assign fetch_latch = (phase_reg == PH_F1) || (phase_reg == PH_T2);

    always_comb
    begin
        if (fetch_latch)
        begin
            sbuf_rd_addr = BW'(perm_rd_data);
        end
        else if (phase_reg == PH_T0)
        begin
            sbuf_rd_addr = BW'(k_reg);
        end
        else
        begin
            sbuf_rd_addr = fetch_pos_reg;
        end
    end

    assign sbuf_wr_en = in_accept && (cmd == pccc_tbe_pkg::CMD_DATA);
    assign perm_wr_en = in_accept && (cmd == pccc_tbe_pkg::CMD_LOAD_PERM)
                        && (int'(table_index) < MAX_BLOCK);

    pccc_tbe_ram #(
        .WIDTH (SymW),
        .DEPTH (MAX_BLOCK)
    ) u_symbol_buffer (
        .clk     (clk),
        .wr_en   (sbuf_wr_en),
        .wr_addr (fill_reg),
        .wr_data (data_symbol),
        .rd_addr (sbuf_rd_addr),
        .rd_data (sbuf_rd_data)
    );

    pccc_tbe_ram #(
        .WIDTH (StateW),
        .DEPTH (MAX_BLOCK)
    ) u_permutation (
        .clk     (clk),
        .wr_en   (perm_wr_en),
        .wr_addr (BW'(table_index)),
        .wr_data (perm_target),
        .rd_addr (fetch_pos_reg),
        .rd_data (perm_rd_data)
    );

    // ------------------------------------------------------------------
    // Symbol checks at T0
    // ------------------------------------------------------------------
    assign k_in_block = BlenW'(k_reg) < BlenW'(len_reg);
    assign bad_one    = NiW'(s1_reg) >= num_inputs_reg;
    assign bad_two    = !k_in_block || (NiW'(sbuf_rd_data) >= num_inputs_reg);
    assign sym_one    = bad_one ? '0 : s1_reg;
    assign sym_two    = bad_two ? '0 : sbuf_rd_data;
    assign bad_now    = bad_one || bad_two;

    // ------------------------------------------------------------------
    // Trellis lanes
    // ------------------------------------------------------------------
    assign lane_ctl.load_addr = (phase_reg == PH_T0) && t0_go;
    assign lane_ctl.load_quot = (phase_reg == PH_T1);

    pccc_tbe_lane #(
        .DEPTH (TableDepth)
    ) u_lane_one (
        .clk           (clk),
        .rst_n         (rst_n),
        .wr_en         (in_accept && (cmd == pccc_tbe_pkg::CMD_LOAD_ONE)),
        .wr_index      (table_index),
        .wr_next_state (next_state_value),
        .wr_out_symbol (out_symbol_value),
        .ctl           (lane_ctl),
        .start_state   (start_one_reg),
        .use_start     (pos_reg == '0),
        .symbol        (sym_one),
        .num_inputs    (num_inputs_reg),
        .next_state    (lane_one_next),
        .out_symbol    (o1)
    );

    pccc_tbe_lane #(
        .DEPTH (TableDepth)
    ) u_lane_two (
        .clk           (clk),
        .rst_n         (rst_n),
        .wr_en         (in_accept && (cmd == pccc_tbe_pkg::CMD_LOAD_TWO)),
        .wr_index      (table_index),
        .wr_next_state (next_state_value),
        .wr_out_symbol (out_symbol_value),
        .ctl           (lane_ctl),
        .start_state   (start_two_reg),
        .use_start     (pos_reg == '0),
        .symbol        (sym_two),
        .num_inputs    (num_inputs_reg),
        .next_state    (lane_two_next),
        .out_symbol    (o2)
    );

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    assign mix = MixW'(o1) * MixW'(num_out2_reg) + MixW'(o2);

    always_ff @(posedge clk)
    begin
        if (fetch_latch)
        begin
            s1_reg <= sbuf_rd_data;
            k_reg  <= perm_rd_data;
        end
        if (lane_ctl.load_addr)
        begin
            bad_reg <= bad_now;
        end
        if (out_load)
        begin
            code_symbol_reg <= mix[CodeW-1:0];
            bad_symbol_reg  <= bad_reg;
            last_reg        <= out_is_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign code_symbol = code_symbol_reg;
    assign bad_symbol  = bad_symbol_reg;
    assign last        = last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `PCCC_TBE_ASSERT_SAME(a_fill_clear_in_pass, phase_reg != PH_IDLE, (fill_reg == '0) && (lane_one_next == lane_one_next) && (lane_two_next == lane_two_next), "fill count not cleared during an encoding pass")
    `PCCC_TBE_ASSERT_SAME(a_final_position, phase_reg == PH_FIN, pos_last, "final hand-over at a position other than the last")
    `PCCC_TBE_ASSERT_NEXT(a_result_per_step, (phase_reg == PH_T0) && t0_go && (pos_reg != '0), out_valid_reg && !last_reg, "position step did not present a non-final result")

endmodule
